@@ design/pwir_pkg.sv @@
// Shared types, constants and helper functions of the pulse-width IR decoder.
package pwir_pkg;

	localparam int unsigned MAX_MSG_BITS = 32;
	localparam int unsigned START_COUNT  = 4;
	localparam int unsigned END_COUNT    = 1;

	localparam int unsigned DUR_W  = 16;
	localparam int unsigned TIME_W = 12;
	localparam int unsigned TOL_W  = 10;
	localparam int unsigned MSGB_W = 6;
	localparam int unsigned IDX_W  = 7;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned CFGI_W = 3;
	localparam int unsigned CFGD_W = 16;

	// Result status codes, in priority order after OK.
	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_START = 3'd1,
		ST_END   = 3'd2,
		ST_GAP   = 3'd3,
		ST_DATA  = 3'd4
	} status_t;

	// Configuration register indexes.
	typedef enum logic [CFGI_W-1:0] {
		REG_MSG_BITS  = 3'd0,
		REG_TOLERANCE = 3'd1,
		REG_ZERO_TIME = 3'd2,
		REG_ONE_TIME  = 3'd3,
		REG_GAP_TIME  = 3'd4,
		REG_TIMEOUT   = 3'd5
	} cfg_idx_t;

	localparam logic [MSGB_W-1:0] RST_MSG_BITS  = 6'd16;
	localparam logic [TOL_W-1:0]  RST_TOLERANCE = 10'd150;
	localparam logic [TIME_W-1:0] RST_ZERO_TIME = 12'd300;
	localparam logic [TIME_W-1:0] RST_ONE_TIME  = 12'd600;
	localparam logic [TIME_W-1:0] RST_GAP_TIME  = 12'd450;
	localparam logic [DUR_W-1:0]  RST_TIMEOUT   = 16'd1000;

	localparam logic [TIME_W-1:0] END_LEN = 12'd800;

	// Fixed lengths of the four start pulses.
	function automatic logic [TIME_W-1:0] start_len(input logic [1:0] idx);
		logic [TIME_W-1:0] len;
		case (idx)
			2'd0:    len = 12'd300;
			2'd1:    len = 12'd700;
			default: len = 12'd500;
		endcase
		return len;
	endfunction

	// True when the measured length lies within +/- tol of the expected one.
	function automatic logic pw_within(input logic [DUR_W-1:0] meas,
			input logic [TIME_W-1:0] expd, input logic [TOL_W-1:0] tol);
		logic [DUR_W:0] hi;
		logic [DUR_W:0] lo;
		hi = {{(DUR_W-TIME_W+1){1'b0}}, expd} + {{(DUR_W-TOL_W+1){1'b0}}, tol};
		lo = {1'b0, meas} + {{(DUR_W-TOL_W+1){1'b0}}, tol};
		return ({1'b0, meas} <= hi) && (lo >= {{(DUR_W-TIME_W+1){1'b0}}, expd});
	endfunction

endpackage

@@ design/pulse_width_ir_decoder_core.sv @@
// Top level of the pulse-width IR frame decoder: input register, frame checks, result register.
//
//  channel  | handshake              | words carried
//  ---------+------------------------+-------------------------------
//  item     | item_valid / item_stall| opcode, duration_us
//  result   | result_valid / stall   | status, data_word
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Every word takes one cycle through the input register and one through the result
// register, so a new word may be taken every cycle. The only loop is the frame state
// (pulse index, fail flags, collected bits), updated by one compare set.
// Reset clears the frame state, loads the configuration defaults and empties both registers.
// A stalled result holds the input register; an empty input register still takes a word.
module pulse_width_ir_decoder_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic                          opcode,
	input  logic [pwir_pkg::DUR_W-1:0]    duration_us,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [2:0]                    status,
	output logic [pwir_pkg::DATA_W-1:0]   data_word,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pwir_pkg::CFGI_W-1:0]   cfg_index,
	input  logic [pwir_pkg::CFGD_W-1:0]   cfg_data
);
	import pwir_pkg::*;

	// Configuration registers.
	logic [MSGB_W-1:0] msg_bits_q;
	logic [TOL_W-1:0]  tolerance_q;
	logic [TIME_W-1:0] zero_time_q;
	logic [TIME_W-1:0] one_time_q;
	logic [TIME_W-1:0] gap_time_q;
	logic [DUR_W-1:0]  timeout_q;

	// Input register.
	logic              valid_s1;
	logic              opcode_s1;
	logic [DUR_W-1:0]  dur_s1;

	// Frame state.
	logic [IDX_W-1:0]  pulse_idx_q;
	logic              start_failed_q;
	logic              gap_failed_q;
	logic              data_failed_q;
	logic [DATA_W-1:0] bits_q;

	// Result register.
	logic              result_valid_q;
	status_t           status_q;
	logic [DATA_W-1:0] data_word_q;

	// Next-state logic.
	logic              advance;
	logic [MSGB_W-1:0] m_eff;
	logic [IDX_W-1:0]  last_idx;
	logic              is_timeout;
	logic [DATA_W-1:0] bit_mask;
	logic [IDX_W-1:0]  k_idx;
	logic              emit;
	status_t           st_d;
	logic [IDX_W-1:0]  pulse_idx_d;
	logic              start_failed_d;
	logic              gap_failed_d;
	logic              data_failed_d;
	logic [DATA_W-1:0] bits_d;

	// The configuration port never pushes back.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_bits_q  <= RST_MSG_BITS;
			tolerance_q <= RST_TOLERANCE;
			zero_time_q <= RST_ZERO_TIME;
			one_time_q  <= RST_ONE_TIME;
			gap_time_q  <= RST_GAP_TIME;
			timeout_q   <= RST_TIMEOUT;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				REG_MSG_BITS:  msg_bits_q  <= cfg_data[MSGB_W-1:0];
				REG_TOLERANCE: tolerance_q <= cfg_data[TOL_W-1:0];
				REG_ZERO_TIME: zero_time_q <= cfg_data[TIME_W-1:0];
				REG_ONE_TIME:  one_time_q  <= cfg_data[TIME_W-1:0];
				REG_GAP_TIME:  gap_time_q  <= cfg_data[TIME_W-1:0];
				REG_TIMEOUT:   timeout_q   <= cfg_data[DUR_W-1:0];
				default: ;
			endcase
		end
	end

	// The held word is processed once the result register is empty or being drained.
	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			opcode_s1 <= opcode;
			dur_s1    <= duration_us;
		end
	end

	always_comb begin
		// A zero bit count acts as one; counts above the maximum are clamped.
		if (msg_bits_q == '0) begin
			m_eff = MSGB_W'(1);
		end else if (msg_bits_q > MSGB_W'(MAX_MSG_BITS)) begin
			m_eff = MSGB_W'(MAX_MSG_BITS);
		end else begin
			m_eff = msg_bits_q;
		end
		last_idx   = IDX_W'({m_eff, 1'b0}) + IDX_W'(START_COUNT + END_COUNT - 1);
		bit_mask   = DATA_W'(({{DATA_W{1'b0}}, 1'b1} << m_eff) - {{DATA_W{1'b0}}, 1'b1});
		is_timeout = opcode_s1 || (dur_s1 > timeout_q);
		k_idx      = pulse_idx_q - IDX_W'(START_COUNT);

		emit           = 1'b0;
		st_d           = ST_OK;
		pulse_idx_d    = pulse_idx_q;
		start_failed_d = start_failed_q;
		gap_failed_d   = gap_failed_q;
		data_failed_d  = data_failed_q;
		bits_d         = bits_q;

		if (is_timeout) begin
			// A timeout closes a frame that has begun; an idle line gives nothing.
			if (pulse_idx_q != '0) begin
				emit = 1'b1;
				if (start_failed_q || pulse_idx_q < IDX_W'(START_COUNT)) begin
					st_d = ST_START;
				end else begin
					st_d = ST_END;
				end
			end
			pulse_idx_d    = '0;
			start_failed_d = 1'b0;
			gap_failed_d   = 1'b0;
			data_failed_d  = 1'b0;
			bits_d         = '0;
		end else if (pulse_idx_q >= last_idx) begin
			// End pulse: report the first failing check in priority order.
			emit = 1'b1;
			if (start_failed_q) begin
				st_d = ST_START;
			end else if (!pw_within(dur_s1, END_LEN, tolerance_q)) begin
				st_d = ST_END;
			end else if (gap_failed_q) begin
				st_d = ST_GAP;
			end else if (data_failed_q) begin
				st_d = ST_DATA;
			end
			pulse_idx_d    = '0;
			start_failed_d = 1'b0;
			gap_failed_d   = 1'b0;
			data_failed_d  = 1'b0;
			bits_d         = '0;
		end else begin
			if (pulse_idx_q < IDX_W'(START_COUNT)) begin
				if (!pw_within(dur_s1, start_len(pulse_idx_q[1:0]), tolerance_q)) begin
					start_failed_d = 1'b1;
				end
			end else if (!k_idx[0]) begin
				// Data pulse; a length matching both the one and zero value reads as one.
				if (pw_within(dur_s1, one_time_q, tolerance_q)) begin
					bits_d[k_idx[5:1]] = 1'b1;
				end else if (!pw_within(dur_s1, zero_time_q, tolerance_q)) begin
					data_failed_d = 1'b1;
				end
			end else begin
				if (!pw_within(dur_s1, gap_time_q, tolerance_q)) begin
					gap_failed_d = 1'b1;
				end
			end
			pulse_idx_d = pulse_idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_idx_q    <= '0;
			start_failed_q <= 1'b0;
			gap_failed_q   <= 1'b0;
			data_failed_q  <= 1'b0;
			bits_q         <= '0;
		end else if (advance) begin
			pulse_idx_q    <= pulse_idx_d;
			start_failed_q <= start_failed_d;
			gap_failed_q   <= gap_failed_d;
			data_failed_q  <= data_failed_d;
			bits_q         <= bits_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= emit;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// Bits at or above the effective message length are cleared in the result.
	always_ff @(posedge clk) begin
		if (advance && emit) begin
			status_q    <= st_d;
			data_word_q <= bits_q & bit_mask;
		end
	end

	assign result_valid = result_valid_q;
	assign status       = status_q;
	assign data_word    = data_word_q;

`ifndef SYNTHESIS
	// The pulse index never runs past the last position of the longest frame.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		pulse_idx_q <= IDX_W'(2 * MAX_MSG_BITS + START_COUNT + END_COUNT - 1))
		else $error("pulse index beyond longest frame");

	// Every word that yields a result leaves the frame state cleared.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit |=> pulse_idx_q == '0 && !start_failed_q && bits_q == '0)
		else $error("frame state not cleared after result");

	// A result never carries bits beyond the configured message length.
	a_mask: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (data_word_q & ~bit_mask) == '0)
		else $error("result holds bits above message length");
`endif

endmodule
